// File: rtl/wav_data_chunk_locator_assert.svh
// Assertion macros shared by the RIFF/WAVE chunk locator RTL.
// Define NO_ASSERTIONS to compile every check out; no other dependencies.
`ifndef WAV_DATA_CHUNK_LOCATOR_ASSERT_SVH
`define WAV_DATA_CHUNK_LOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define WDCL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Check a property at every edge, reset cycles included.
`define WDCL_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define WDCL_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define WDCL_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// File: rtl/wdcl_pkg.sv
// Shared types, codes and constants of the RIFF/WAVE data chunk locator.
// No dependencies; compile first.
package wdcl_pkg;

  localparam int POS_BITS_DEFAULT = 32;
  localparam int RIFF_LEN         = 12;
  localparam int HDR_LEN          = 8;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;  // "data", first byte high

  typedef enum logic [1:0] {
    ST_SEARCH  = 2'd0,
    ST_FOUND   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     parse_status;
    logic [31:0] pcm_offset;
    logic        file_done;
  } result_t;

  // Expected byte of the 12-byte RIFF/WAVE preamble; bit 8 flags a checked place.
  function automatic logic [8:0] riff_byte(input logic [3:0] idx);
    logic [8:0] pat;
    case (idx)
      4'd0:    pat = {1'b1, 8'h52};  // R
      4'd1:    pat = {1'b1, 8'h49};  // I
      4'd2:    pat = {1'b1, 8'h46};  // F
      4'd3:    pat = {1'b1, 8'h46};  // F
      4'd8:    pat = {1'b1, 8'h57};  // W
      4'd9:    pat = {1'b1, 8'h41};  // A
      4'd10:   pat = {1'b1, 8'h56};  // V
      4'd11:   pat = {1'b1, 8'h45};  // E
      default: pat = 9'd0;           // RIFF size field, not checked
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/wdcl_in_if.sv
// Byte channel into the chunk locator: valid/ready handshake plus payload.
// No dependencies.
interface wdcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// File: rtl/wdcl_out_if.sv
// Result channel out of the chunk locator: valid/ready handshake plus payload.
// No dependencies.
interface wdcl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  parse_status;
  logic [31:0] pcm_offset;
  logic        file_done;

  modport source (output valid, parse_status, pcm_offset, file_done, input ready);
  modport sink   (input valid, parse_status, pcm_offset, file_done, output ready);
endinterface

// File: rtl/wdcl_parse_core.sv
// Parser state and per-byte update of the RIFF/WAVE chunk walk.
// Depends on wdcl_pkg and wav_data_chunk_locator_assert.svh.
`include "wav_data_chunk_locator_assert.svh"

module wdcl_parse_core
  import wdcl_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [1:0] {PH_RIFF, PH_HDR, PH_SKIP, PH_DONE} phase_t;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [31:0]              id_r, id_nxt;
  logic [31:0]              size_r, size_nxt;
  logic [32:0]              skip_r, skip_nxt;
  logic                     match_r, match_nxt;
  status_t                  status_r, status_nxt;
  logic [31:0]              offset_r, offset_nxt;

  logic [POSITION_BITS-1:0] count;
  logic [32:0]              skip_dec;
  logic [31:0]              id_upd;
  logic [31:0]              size_upd;
  logic [2:0]               hdr_idx;
  logic [8:0]               pat;
  phase_t                   phase_eff;
  status_t                  st;

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    size_nxt   = size_r;
    skip_nxt   = skip_r;
    match_nxt  = match_r;
    status_nxt = status_r;
    offset_nxt = offset_r;
    id_upd     = id_r;
    size_upd   = size_r;

    // Saturate the byte counter; hitting the top while undecided is a failure.
    count     = (&pos_r) ? pos_r : pos_r + 1'b1;
    pos_nxt   = count;
    phase_eff = phase_r;
    if ((&pos_r) && (phase_r != PH_DONE)) begin
      status_nxt = ST_INVALID;
      phase_nxt  = PH_DONE;
      phase_eff  = PH_DONE;
    end

    skip_dec = (skip_r != '0) ? skip_r - 33'd1 : '0;
    hdr_idx  = 3'(4'(HDR_LEN) - skip_r[3:0]);
    pat      = riff_byte(pos_r[3:0]);

    case (phase_eff)
      PH_RIFF: begin
        match_nxt = match_r & (~pat[8] | (pat[7:0] == item.data_byte));
        if (pos_r >= POSITION_BITS'(RIFF_LEN - 1)) begin
          if (match_nxt) begin
            phase_nxt = PH_HDR;
            skip_nxt  = 33'(HDR_LEN);
            id_nxt    = '0;
            size_nxt  = '0;
          end else begin
            status_nxt = ST_INVALID;
            phase_nxt  = PH_DONE;
          end
        end
      end
      PH_HDR: begin
        // First four bytes shift into the id, next four fill the size lanes.
        if (!hdr_idx[2]) begin
          id_upd = {id_r[23:0], item.data_byte};
        end else begin
          case (hdr_idx[1:0])
            2'd0:    size_upd = size_r | {24'd0, item.data_byte};
            2'd1:    size_upd = size_r | {16'd0, item.data_byte, 8'd0};
            2'd2:    size_upd = size_r | {8'd0, item.data_byte, 16'd0};
            default: size_upd = size_r | {item.data_byte, 24'd0};
          endcase
        end
        id_nxt   = id_upd;
        size_nxt = size_upd;
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          if (id_upd == ID_DATA) begin
            status_nxt = ST_FOUND;
            offset_nxt = 32'(count);
            phase_nxt  = PH_DONE;
          end else if (size_upd == '0) begin
            // Empty chunk: next header starts at once.
            skip_nxt = 33'(HDR_LEN);
            id_nxt   = '0;
            size_nxt = '0;
          end else begin
            // Odd sizes carry one pad byte.
            skip_nxt  = {1'b0, size_upd} + {32'd0, size_upd[0]};
            phase_nxt = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_HDR;
          skip_nxt  = 33'(HDR_LEN);
          id_nxt    = '0;
          size_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    st = status_nxt;
    if (item.last_byte && (st == ST_SEARCH)) begin
      st = ST_INVALID;
    end
    result.parse_status = st;
    result.pcm_offset   = (st == ST_FOUND) ? offset_nxt : 32'd0;
    result.file_done    = item.last_byte;

    // Last byte answered: start the next file from scratch.
    if (item.last_byte) begin
      pos_nxt    = '0;
      phase_nxt  = PH_RIFF;
      id_nxt     = '0;
      size_nxt   = '0;
      skip_nxt   = '0;
      match_nxt  = 1'b1;
      status_nxt = ST_SEARCH;
      offset_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_RIFF;
      id_r     <= '0;
      size_r   <= '0;
      skip_r   <= '0;
      match_r  <= 1'b1;
      status_r <= ST_SEARCH;
      offset_r <= '0;
    end else if (step_en) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      id_r     <= id_nxt;
      size_r   <= size_nxt;
      skip_r   <= skip_nxt;
      match_r  <= match_nxt;
      status_r <= status_nxt;
      offset_r <= offset_nxt;
    end
  end

  `WDCL_ASSERT(a_found_is_done, clk, rst_n, (status_r == ST_FOUND) |-> (phase_r == PH_DONE), "found status outside done phase")
  `WDCL_ASSERT(a_hdr_count, clk, rst_n, (phase_r == PH_HDR) |-> (skip_r != '0 && skip_r <= 33'(HDR_LEN)), "header byte count out of range")
  `WDCL_ASSERT(a_skip_nonzero, clk, rst_n, (phase_r == PH_SKIP) |-> (skip_r != '0), "body skip with zero bytes left")
  `WDCL_ASSERT(a_riff_window, clk, rst_n, (phase_r == PH_RIFF) |-> (pos_r < POSITION_BITS'(RIFF_LEN)), "preamble phase past byte 11")

endmodule

// File: rtl/wav_data_chunk_locator.sv
// Top level of the RIFF/WAVE data chunk locator: input word register,
// parser core and result register. Depends on wdcl_pkg, wdcl_in_if,
// wdcl_out_if, wdcl_parse_core and wav_data_chunk_locator_assert.svh.
//
// Usage: feed a WAV file one byte per word on in_ch, in file order, with
// last_byte set on its final byte. Every byte yields exactly one result word
// on out_ch: parse_status (searching, found or invalid), pcm_offset (offset
// just past the "data" chunk header when found, else 0) and file_done (set
// on the result of the last byte). The status is sticky for the file; the
// word after a last byte starts a new file.
// Throughput: one byte per clock while out_ch.ready is high. The per-byte
// work (preamble compare, header gather, skip count decrement) sits in a
// single stage between the input register and the result register.
// Path: a byte accepted into the input register has its result word loaded
// into the result register when the parser core steps on that byte.
// Stall: when out_ch.ready is low with a result word waiting, the result
// register holds, and in_ch.ready drops once the input register holds a byte.
// Reset (rst_n low, synchronous): both registers empty, parser back to the
// start of a file.
`include "wav_data_chunk_locator_assert.svh"

module wav_data_chunk_locator
  import wdcl_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  wdcl_in_if.sink     in_ch,
  wdcl_out_if.source  out_ch
);

  logic    s1_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t core_res;
  logic    s1_adv;
  logic    step_en;

  // Advance the input stage whenever the result register is free or draining.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign step_en     = s1_valid_r && s1_adv;

  // Input word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

  wdcl_parse_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .result  (core_res)
  );

  // Result register: load the core's answer as the parser state advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parse_status = res_r.parse_status;
  assign out_ch.pcm_offset   = res_r.pcm_offset;
  assign out_ch.file_done    = res_r.file_done;

  `WDCL_ASSERT(a_offset_only_found, clk, rst_n, (out_valid_r && res_r.parse_status != ST_FOUND) |-> (res_r.pcm_offset == 32'd0), "offset set without found status")
  `WDCL_ASSERT(a_status_code, clk, rst_n, out_valid_r |-> (res_r.parse_status == ST_SEARCH || res_r.parse_status == ST_FOUND || res_r.parse_status == ST_INVALID), "undefined status code on output")
  `WDCL_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule
